### hdl/bsa_pkg.sv
// shared constants and types of the bump and slab entry allocator
// no dependencies
package bsa_pkg;

  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned SlabSizeDef     = 4;

  localparam int unsigned CountWidth  = 11;
  localparam int unsigned BaseWidth   = 10;
  localparam int unsigned IndexWidth  = 10;
  localparam int unsigned StatusWidth = 2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_LEAKED  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

endpackage

### hdl/bsa_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module bsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bump_and_slab_entry_allocator_core.sv
// allocator core: bump pointer plus slab free list, links held in bsa_ram
// depends on bsa_pkg and bsa_ram
// result word registered in the cycle after accept, except a slab pop, which first reads its link in StPop
// throughput: one word every cycle while neither a full result register nor a slab pop holds it
// a new word is taken while the result register is empty or being drained and no slab pop is in StPop
// reset: asynchronous active low, top cleared and free list empty, no ram clear
module bump_and_slab_entry_allocator_core #(
  parameter int unsigned TABLE_ENTRIES = bsa_pkg::TableEntriesDef,
  parameter int unsigned SLAB_SIZE     = bsa_pkg::SlabSizeDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [bsa_pkg::CountWidth-1:0]   entry_count_i,
  input  logic [bsa_pkg::BaseWidth-1:0]    run_base_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bsa_pkg::IndexWidth-1:0]   granted_index_o,
  output logic [bsa_pkg::StatusWidth-1:0]  status_o
);
  import bsa_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CalcW = ((AddrW > CountWidth) ? AddrW : CountWidth) + 2;
  localparam int unsigned LinkW = AddrW + 1;

  typedef enum logic {
    StIdle,
    StPop
  } state_e;

  typedef logic [IndexWidth-1:0] granted_t;

  state_e               state_q, state_d;
  logic [AddrW-1:0]     top_q, top_d;
  logic [AddrW-1:0]     head_q, head_d;
  logic                 head_valid_q, head_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [IndexWidth-1:0] granted_q, granted_d;
  status_e              status_q, status_d;

  logic                 in_acc;
  logic [CalcW-1:0]     cnt, base, top, tbl, slab, base_end;
  logic                 mem_we, mem_re;
  logic [LinkW-1:0]     mem_rdata;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign cnt      = CalcW'(entry_count_i);
  assign base     = CalcW'(run_base_i);
  assign top      = CalcW'(top_q);
  assign tbl      = CalcW'(TABLE_ENTRIES);
  assign slab     = CalcW'(SLAB_SIZE);
  assign base_end = base + cnt;

  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    granted_d    = granted_q;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          granted_d = '0;
          status_d  = ST_OK;
          if (opcode_i == OpAlloc) begin
            priority if (cnt == slab && head_valid_q) begin
              mem_re  = 1'b1;
              state_d = StPop;
            end else if (top + cnt < tbl) begin
              granted_d   = top[IndexWidth-1:0];
              top_d       = top_d + cnt[AddrW-1:0];
              out_valid_d = 1'b1;
            end else begin
              status_d    = ST_NOSPACE;
              out_valid_d = 1'b1;
            end
          end else begin
            out_valid_d = 1'b1;
            priority if (cnt != '0 && (base >= tbl || base_end - CalcW'(1) >= tbl)) begin
              status_d = ST_RANGE;
            end else if (base_end == top) begin
              top_d = base[AddrW-1:0];
            end else if (cnt == slab) begin
              mem_we       = 1'b1;
              head_d       = base[AddrW-1:0];
              head_valid_d = 1'b1;
            end else begin
              status_d = ST_LEAKED;
            end
          end
        end
      end
      StPop: begin
        granted_d    = granted_t'(head_q);
        head_d       = mem_rdata[AddrW-1:0];
        head_valid_d = mem_rdata[AddrW];
        out_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      top_q        <= '0;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      granted_q    <= '0;
      status_q     <= ST_OK;
    end else begin
      state_q      <= state_d;
      top_q        <= top_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      out_valid_q  <= out_valid_d;
      granted_q    <= granted_d;
      status_q     <= status_d;
    end
  end

  bsa_ram #(
    .Width (LinkW),
    .Depth (TABLE_ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (base[AddrW-1:0]),
    .wdata_i ({head_valid_q, head_q}),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;

endmodule

### hdl/bsa_checker.sv
// port level checks of the allocator core, bound to the allocator core module
// depends on bsa_pkg and bump_and_slab_entry_allocator_core
module bsa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [bsa_pkg::IndexWidth-1:0]   granted_index_o,
  input logic [bsa_pkg::StatusWidth-1:0]  status_o
);
  import bsa_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_index_o)
      && $stable(status_o))
    else $error("stalled result word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_index_o == '0)
    else $error("nonzero index on a failed or free word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_o || out_ready_i)
    else $error("word taken while result register full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 ($past(out_valid_o) || out_valid_o))
    else $error("no result word within two cycles");

endmodule

bind bump_and_slab_entry_allocator_core bsa_checker u_bsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .granted_index_o (granted_index_o),
  .status_o        (status_o)
);

### tb/alloc_tb_pkg.sv
// scoreboard for the bump and slab entry allocator: predicts each result word
// on accept and checks result words in order; depends on bsa_pkg
package alloc_tb_pkg;
  import bsa_pkg::*;

  typedef struct packed {
    logic [IndexWidth-1:0] granted;
    status_e               status;
  } grant_word_t;

  class grant_scoreboard;
    int unsigned          bump_top;
    logic [BaseWidth-1:0] head;
    bit                   head_valid;
    logic [BaseWidth-1:0] link [TableEntriesDef];
    bit                   link_valid [TableEntriesDef];
    grant_word_t          pending_grants [$];
    int                   errors;

    function new();
      bump_top   = 0;
      head       = '0;
      head_valid = 1'b0;
      errors     = 0;
      foreach (link[i]) begin
        link[i]       = '0;
        link_valid[i] = 1'b0;
      end
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // apply one accepted request word and queue the result word it causes
    function grant_word_t note_request(logic op, logic [CountWidth-1:0] count,
                                       logic [BaseWidth-1:0] base);
      grant_word_t          res;
      logic [BaseWidth-1:0] popped;
      int unsigned          cnt;
      int unsigned          b;
      cnt        = 32'(count);
      b          = 32'(base);
      res.granted = '0;
      res.status  = ST_OK;
      if (op == OpAlloc) begin
        if (cnt == SlabSizeDef && head_valid) begin
          popped             = head;
          res.granted        = popped;
          head               = link[popped];
          head_valid         = link_valid[popped];
          link[popped]       = '0;
          link_valid[popped] = 1'b0;
        end else if (bump_top + cnt < TableEntriesDef) begin
          res.granted = bump_top[IndexWidth-1:0];
          bump_top    = bump_top + cnt;
        end else begin
          res.status = ST_NOSPACE;
        end
      end else begin
        if (cnt > 0 && (b >= TableEntriesDef || b + cnt - 1 >= TableEntriesDef)) begin
          res.status = ST_RANGE;
        end else if (b + cnt == bump_top) begin
          bump_top = b;
        end else if (cnt == SlabSizeDef) begin
          link[base]       = head;
          link_valid[base] = head_valid;
          head             = base;
          head_valid       = 1'b1;
        end else begin
          res.status = ST_LEAKED;
        end
      end
      pending_grants.push_back(res);
      return res;
    endfunction

    function void check_grant(logic [IndexWidth-1:0] granted,
                              logic [StatusWidth-1:0] status);
      grant_word_t exp;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result word granted_index %0d status %0d",
                 $time, granted, status);
        errors++;
        return;
      end
      exp = pending_grants.pop_front();
      if (granted !== exp.granted) begin
        $display("%0t: granted_index expected %0d actual %0d",
                 $time, exp.granted, granted);
        errors++;
      end
      if (status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/testbench.sv
// top of the allocator testbench: clock, reset, request driver, result sink
// depends on bsa_pkg, alloc_tb_pkg and bump_and_slab_entry_allocator_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;
  import alloc_tb_pkg::*;

  localparam int RandomWords = 1300;

  typedef struct packed {
    logic                  op;
    logic [CountWidth-1:0] count;
    logic [BaseWidth-1:0]  base;
  } request_t;

  typedef struct {
    int unsigned base;
    int unsigned count;
  } run_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   opcode = 1'b0;
  logic [CountWidth-1:0]  entry_count = '0;
  logic [BaseWidth-1:0]   run_base = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [IndexWidth-1:0]  granted_index;
  logic [StatusWidth-1:0] status;

  grant_scoreboard sb = new();
  run_t            live_runs [$];
  int              words_sent = 0;

  request_t directed_words [25] = '{
    '{OpAlloc, 11'd0,    10'd0},
    '{OpFree,  11'd0,    10'd0},
    '{OpFree,  11'd0,    10'd5},
    '{OpFree,  11'd1,    10'd1023},
    '{OpFree,  11'd2,    10'd1023},
    '{OpFree,  11'd2047, 10'd0},
    '{OpFree,  11'd1024, 10'd0},
    '{OpAlloc, 11'd4,    10'd1023},
    '{OpAlloc, 11'd4,    10'd0},
    '{OpAlloc, 11'd3,    10'd0},
    '{OpFree,  11'd4,    10'd0},
    '{OpFree,  11'd4,    10'd4},
    '{OpAlloc, 11'd4,    10'd0},
    '{OpAlloc, 11'd4,    10'd0},
    '{OpAlloc, 11'd4,    10'd0},
    '{OpFree,  11'd4,    10'd11},
    '{OpFree,  11'd3,    10'd8},
    '{OpAlloc, 11'd1016, 10'd0},
    '{OpAlloc, 11'd1015, 10'd0},
    '{OpAlloc, 11'd0,    10'd0},
    '{OpAlloc, 11'd1,    10'd0},
    '{OpAlloc, 11'd2047, 10'd1023},
    '{OpFree,  11'd1015, 10'd8},
    '{OpFree,  11'd1,    10'd1023},
    '{OpFree,  11'd8,    10'd0}
  };

  bump_and_slab_entry_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .entry_count_i   (entry_count),
    .run_base_i      (run_base),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .granted_index_o (granted_index),
    .status_o        (status)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_grant(granted_index, status);
    end
  end

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_word(input request_t w);
    grant_word_t exp;
    in_valid    <= 1'b1;
    opcode      <= w.op;
    entry_count <= w.count;
    run_base    <= w.base;
    do @(posedge clk_i); while (!in_ready);
    exp = sb.note_request(w.op, w.count, w.base);
    words_sent++;
    if (w.op == OpAlloc && exp.status == ST_OK && w.count != 0 && live_runs.size() < 64) begin
      live_runs.push_back('{32'(exp.granted), 32'(w.count)});
    end
    for (int i = live_runs.size() - 1; i >= 0; i--) begin
      if (live_runs[i].base + live_runs[i].count > sb.bump_top) live_runs.delete(i);
    end
    @(negedge clk_i);
  endtask

  function automatic request_t pick_word();
    request_t    w;
    int unsigned r;
    int unsigned c;
    int unsigned idx;
    int unsigned b;
    r      = $urandom_range(0, 99);
    w.base = BaseWidth'($urandom_range(0, 1023));
    if (r < 50) begin
      w.op = OpAlloc;
      c    = $urandom_range(0, 99);
      if (c < 45)      w.count = CountWidth'(SlabSizeDef);
      else if (c < 80) w.count = CountWidth'($urandom_range(1, 12));
      else if (c < 85) w.count = '0;
      else if (c < 95) w.count = CountWidth'($urandom_range(20, 300));
      else             w.count = CountWidth'($urandom_range(0, 2047));
    end else if (r < 88 && live_runs.size() != 0) begin
      w.op = OpFree;
      idx  = $urandom_range(0, 1) ? 32'(live_runs.size() - 1)
                                  : $urandom_range(0, live_runs.size() - 1);
      w.base  = BaseWidth'(live_runs[idx].base);
      w.count = CountWidth'(live_runs[idx].count);
      live_runs.delete(idx);
    end else begin
      w.op = OpFree;
      c    = $urandom_range(0, 99);
      if (c < 25) begin
        b       = $urandom_range(0, sb.bump_top);
        w.base  = (b > 1023) ? 10'd1023 : BaseWidth'(b);
        w.count = CountWidth'(sb.bump_top - 32'(w.base));
      end else if (c < 50) begin
        w.count = CountWidth'(SlabSizeDef);
      end else if (c < 75) begin
        w.count = CountWidth'($urandom_range(0, 8));
      end else begin
        w.count = CountWidth'($urandom_range(0, 2047));
      end
    end
    return w;
  endfunction

  initial begin
    int  gap;
    int  burst;
    int  n;
    bit  mid_done;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
      gap = $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    n        = 0;
    mid_done = 1'b0;
    in_valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);

    while (n < RandomWords) begin
      if (!mid_done && n >= RandomWords / 2) begin
        mid_done = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk_i); while (sb.pending() != 0);
      end
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_word(pick_word());
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // result sink: stall segments of varied shape, with one long hold-off once 150 words are sent
  initial begin
    int          seg;
    int          mode;
    logic [15:0] pat;
    bit          long_done;
    long_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_done && words_sent >= 150) begin
        long_done = 1'b1;
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (299) @(negedge clk_i);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 60);
      pat  = 16'($urandom);
      repeat (seg) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
